>>> hw/rtl/dpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pkg: shared definitions of the depth pixel back-projection unit
// Field widths, register indexes, pipeline geometry and derived datapath
// widths used by the pipeline control, the axis datapath and the top level.
// ----------------------------------------------------------------------------
package dpb_pkg;

    // Field widths.
    localparam int DEPTH_W    = 16;
    localparam int PIX_W      = 12;
    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 21;
    localparam int INV_W      = 24;
    localparam int CTR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Pixel coordinates at or beyond this limit are clamped to one below it.
    localparam int MAX_COORD  = 4096;

    // Pipeline geometry: offset, first product, second product, rounding.
    localparam int NSTAGE     = 4;

    // Derived datapath widths.
    localparam int CLAMP_W    = $clog2(MAX_COORD);
    localparam int PIX16_W    = CLAMP_W + 4;
    localparam int MAG_W      = (PIX16_W > CTR_W) ? PIX16_W : CTR_W;
    localparam int PROD1_W    = MAG_W + DEPTH_W;
    localparam int PROD2_W    = PROD1_W + INV_W;
    localparam int ROUND_SHIFT = 28;
    localparam int RND_W      = PROD2_W + 1 - ROUND_SHIFT;

    localparam logic [PROD2_W:0] ROUND_HALF = (PROD2_W + 1)'(1) << (ROUND_SHIFT - 1);
    localparam logic [RND_W-1:0] COORD_MAX_POS = RND_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [RND_W-1:0] COORD_MAX_NEG = RND_W'(64'd1 << (COORD_W - 1));

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FOCAL_X = 2'd0,
        REG_INV_FOCAL_Y = 2'd1,
        REG_CENTER_X    = 2'd2,
        REG_CENTER_Y    = 2'd3
    } t_cfg_idx;

    // Register reset values.
    localparam logic [INV_W-1:0] INV_FOCAL_RST = INV_W'(33554);
    localparam logic [CTR_W-1:0] CENTER_X_RST  = CTR_W'(15360);
    localparam logic [CTR_W-1:0] CENTER_Y_RST  = CTR_W'(8640);

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_stage_ctl;

endpackage : dpb_pkg
`default_nettype wire

>>> hw/rtl/dpb_pipe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pipe_ctrl: valid tracking and stall control of the pipeline
// Keeps one valid bit per stage and derives the load enable of each stage so
// that bubbles are squeezed out and a stalled request is held in place.
// ----------------------------------------------------------------------------
module dpb_pipe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output dpb_pkg::t_stage_ctl      o_ctl
);
    import dpb_pkg::*;

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] n_v;
    logic [NSTAGE:0]   ready;

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        ready[NSTAGE] = ~i_stall;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            ready[k] = ~r_v[k] | ready[k + 1];
        end
    end

    // Next valid bits: each loading stage takes the valid of the one before it.
    always_comb begin
        n_v = r_v;
        if (ready[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (ready[k]) begin
                n_v[k] = r_v[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ctl.en = ready[NSTAGE-1:0];
    assign o_stall  = ~ready[0];
    assign o_valid  = r_v[NSTAGE-1];

endmodule : dpb_pipe_ctrl
`default_nettype wire

>>> hw/rtl/dpb_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_axis: back-projection datapath of one image axis
// Forms the signed offset from the principal point, multiplies by depth and
// by the reciprocal focal length, then rounds and saturates to 21 bits.
// ----------------------------------------------------------------------------
module dpb_axis (
    input  wire logic                          i_clk,
    input  wire dpb_pkg::t_stage_ctl           i_ctl,
    input  wire logic [dpb_pkg::PIX_W-1:0]     i_pix,
    input  wire logic [dpb_pkg::CTR_W-1:0]     i_center,
    input  wire logic [dpb_pkg::INV_W-1:0]     i_inv,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]   i_depth_s0,
    output logic [dpb_pkg::COORD_W-1:0]        o_coord,
    output logic                               o_sat
);
    import dpb_pkg::*;

    logic [CLAMP_W-1:0] pix_c;
    logic [MAG_W-1:0]   p16_e;
    logic [MAG_W-1:0]   ctr_e;
    logic               neg;
    logic [MAG_W-1:0]   mag;

    logic [MAG_W-1:0]   r_mag;
    logic               r_neg0;
    logic [PROD1_W-1:0] r_prod1;
    logic               r_neg1;
    logic [PROD2_W-1:0] r_prod2;
    logic               r_neg2;

    logic [PROD2_W:0]   rsum;
    logic [RND_W-1:0]   rnd;
    logic [RND_W-1:0]   rclip;
    logic               sat;
    logic [COORD_W-1:0] coord;

    // Clamp the pixel index and form the magnitude and sign of the offset.
    always_comb begin
        if (32'(i_pix) > 32'(MAX_COORD - 1)) begin
            pix_c = CLAMP_W'(MAX_COORD - 1);
        end else begin
            pix_c = CLAMP_W'(i_pix);
        end
        p16_e = MAG_W'({pix_c, 4'b0000});
        ctr_e = MAG_W'(i_center);
        neg   = p16_e < ctr_e;
        mag   = neg ? (ctr_e - p16_e) : (p16_e - ctr_e);
    end

    // Stage 0 holds the offset, stage 1 the depth product, stage 2 the full product.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_mag  <= mag;
            r_neg0 <= neg;
        end
        if (i_ctl.en[1]) begin
            r_prod1 <= PROD1_W'(r_mag) * PROD1_W'(i_depth_s0);
            r_neg1  <= r_neg0;
        end
        if (i_ctl.en[2]) begin
            r_prod2 <= PROD2_W'(r_prod1) * PROD2_W'(i_inv);
            r_neg2  <= r_neg1;
        end
    end

    // Round half away from zero on the magnitude, clip, then apply the sign.
    always_comb begin
        rsum = {1'b0, r_prod2} + ROUND_HALF;
        rnd  = rsum[PROD2_W:ROUND_SHIFT];
        if (!r_neg2) begin
            sat   = rnd > COORD_MAX_POS;
            rclip = sat ? COORD_MAX_POS : rnd;
            coord = COORD_W'(rclip);
        end else begin
            sat   = rnd > COORD_MAX_NEG;
            rclip = sat ? COORD_MAX_NEG : rnd;
            coord = ~COORD_W'(rclip) + COORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            o_coord <= coord;
            o_sat   <= sat;
        end
    end

endmodule : dpb_axis
`default_nettype wire

>>> hw/rtl/depth_pixel_backprojection_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit: pinhole back-projection of depth pixels
// Turns a depth pixel with its color into a 3-D point in millimeters.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while i_stall is low; a request passes
// through the four pipeline registers (offset, depth product, focal product,
// rounding) in order, and each takes a new request whenever it is free.
// Reset clears all valid bits and loads the intrinsics with their default
// values; no clearing pass is needed.
module depth_pixel_backprojection_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration port.
    input  wire logic                              i_cfg_we,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]       i_depth_mm,
    input  wire logic [dpb_pkg::PIX_W-1:0]         i_col,
    input  wire logic [dpb_pkg::PIX_W-1:0]         i_row,
    input  wire logic [dpb_pkg::COLOR_W-1:0]       i_blue_in,
    input  wire logic [dpb_pkg::COLOR_W-1:0]       i_green_in,
    input  wire logic [dpb_pkg::COLOR_W-1:0]       i_red_in,
    // Output channel.
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [dpb_pkg::COORD_W-1:0]     o_point_x,
    output logic signed [dpb_pkg::COORD_W-1:0]     o_point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]            o_point_z,
    output logic [dpb_pkg::COLOR_W-1:0]            o_blue_out,
    output logic [dpb_pkg::COLOR_W-1:0]            o_green_out,
    output logic [dpb_pkg::COLOR_W-1:0]            o_red_out,
    output logic                                   o_point_valid,
    output logic                                   o_coord_saturated
);
    import dpb_pkg::*;

    logic [INV_W-1:0]   r_inv_fx;
    logic [INV_W-1:0]   r_inv_fy;
    logic [CTR_W-1:0]   r_ctr_x;
    logic [CTR_W-1:0]   r_ctr_y;

    t_stage_ctl         ctl;

    logic [DEPTH_W-1:0] r_depth [NSTAGE];
    logic [COLOR_W-1:0] r_blue  [NSTAGE];
    logic [COLOR_W-1:0] r_green [NSTAGE];
    logic [COLOR_W-1:0] r_red   [NSTAGE];

    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic               sat_x;
    logic               sat_y;
    logic               zero;

    // Configuration registers; an unused index leaves them unchanged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= INV_FOCAL_RST;
            r_inv_fy <= INV_FOCAL_RST;
            r_ctr_x  <= CENTER_X_RST;
            r_ctr_y  <= CENTER_Y_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_INV_FOCAL_X: r_inv_fx <= INV_W'(i_cfg_data);
                REG_INV_FOCAL_Y: r_inv_fy <= INV_W'(i_cfg_data);
                REG_CENTER_X:    r_ctr_x  <= CTR_W'(i_cfg_data);
                REG_CENTER_Y:    r_ctr_y  <= CTR_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Pipeline valid bits and stage enables.
    dpb_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    // Depth and color travel alongside the coordinate datapaths.
    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_depth[0] <= i_depth_mm;
            r_blue[0]  <= i_blue_in;
            r_green[0] <= i_green_in;
            r_red[0]   <= i_red_in;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (ctl.en[k]) begin
                r_depth[k] <= r_depth[k - 1];
                r_blue[k]  <= r_blue[k - 1];
                r_green[k] <= r_green[k - 1];
                r_red[k]   <= r_red[k - 1];
            end
        end
    end

    // Horizontal axis.
    dpb_axis u_axis_x (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_pix      (i_col),
        .i_center   (r_ctr_x),
        .i_inv      (r_inv_fx),
        .i_depth_s0 (r_depth[0]),
        .o_coord    (coord_x),
        .o_sat      (sat_x)
    );

    // Vertical axis.
    dpb_axis u_axis_y (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_pix      (i_row),
        .i_center   (r_ctr_y),
        .i_inv      (r_inv_fy),
        .i_depth_s0 (r_depth[0]),
        .o_coord    (coord_y),
        .o_sat      (sat_y)
    );

    // A zero depth marks a bad point and clears every result field.
    assign zero              = (r_depth[NSTAGE-1] == '0);
    assign o_point_x         = zero ? '0 : coord_x;
    assign o_point_y         = zero ? '0 : coord_y;
    assign o_point_z         = r_depth[NSTAGE-1];
    assign o_blue_out        = zero ? '0 : r_blue[NSTAGE-1];
    assign o_green_out       = zero ? '0 : r_green[NSTAGE-1];
    assign o_red_out         = zero ? '0 : r_red[NSTAGE-1];
    assign o_point_valid     = ~zero;
    assign o_coord_saturated = ~zero & (sat_x | sat_y);

endmodule : depth_pixel_backprojection_unit
`default_nettype wire
